// ===== design/hbbc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Hashed block buffer cache package
// Shared sizes, operation and status codes, controller commands and the
// reset image of the bucket link lists.
// ----------------------------------------------------------------------------
package hbbc_pkg;

  localparam int NUM_BUFFERS = 32;
  localparam int NUM_BUCKETS = 13;
  localparam int NODE_COUNT  = NUM_BUFFERS + NUM_BUCKETS;

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int BUF_W  = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int STEP_W = $clog2(NODE_COUNT + 1);

  localparam int OP_W  = 2;
  localparam int DEV_W = 16;
  localparam int BLK_W = 32;
  localparam int IDX_W = 5;
  localparam int ST_W  = 2;
  localparam int CNT_W = 8;

  // Block number is reduced four bits at a time, most significant first.
  localparam int MOD_DIGITS = BLK_W / 4;
  localparam int DIG_W      = $clog2(MOD_DIGITS);

  typedef enum logic [OP_W-1:0] {
    OP_GET     = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PIN     = 2'd2,
    OP_UNPIN   = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_MOD_TAG,
    CMD_MOD_STEP,
    CMD_RD_HEAD_NEXT,
    CMD_LOAD_NEXT_FIRST,
    CMD_RD_NODE_NEXT,
    CMD_ADV_NEXT,
    CMD_HIT,
    CMD_SCAN_INIT,
    CMD_RD_SCAN_PREV,
    CMD_LOAD_PREV_FIRST,
    CMD_RD_NODE_PREV,
    CMD_ADV_PREV,
    CMD_NEXT_BUCKET,
    CMD_RD_LINKS,
    CMD_UNLINK,
    CMD_PUSH_A,
    CMD_PUSH_B,
    CMD_RETAG,
    CMD_NO_FREE,
    CMD_COUNT,
    CMD_EMIT
  } cmd_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MOD,
    S_SRCH_HEAD,
    S_SRCH_FIRST,
    S_SRCH_CHK,
    S_SRCH_ADV,
    S_SCAN_HEAD,
    S_SCAN_FIRST,
    S_SCAN_CHK,
    S_SCAN_ADV,
    S_COUNT,
    S_REL_TAG,
    S_LNK_RD,
    S_LNK_UNLINK,
    S_LNK_HEAD,
    S_LNK_PUSH_A,
    S_LNK_PUSH_B,
    S_RETAG,
    S_DONE
  } ctl_state_e;

  typedef struct packed {
    op_e  op;
    logic mod_last;
    logic srch_end;
    logic scan_end;
    logic tag_match;
    logic cnt_zero;
    logic last_bucket;
    logic relink;
    logic out_busy;
  } dp_status_t;

  typedef logic [NODE_W-1:0] link_tab_t [NODE_COUNT];

  // Builds the reset lists: empty heads, then each buffer pushed at the
  // most recently used end of its initial bucket.
  function automatic link_tab_t init_links(input bit want_next);
    link_tab_t nxt;
    link_tab_t prv;
    int        h;
    int        f;
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      nxt[NUM_BUFFERS + i] = NODE_W'(NUM_BUFFERS + i);
      prv[NUM_BUFFERS + i] = NODE_W'(NUM_BUFFERS + i);
    end
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      h      = NUM_BUFFERS + (i % NUM_BUCKETS);
      f      = int'(nxt[h]);
      nxt[i] = NODE_W'(f);
      prv[i] = NODE_W'(h);
      prv[f] = NODE_W'(i);
      nxt[h] = NODE_W'(i);
    end
    return want_next ? nxt : prv;
  endfunction

endpackage
`default_nettype wire

// ===== design/hashed_block_buffer_cache.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Hashed block buffer cache
// Tag and replacement engine: hashed bucket lists kept in most recently used
// order, reference counting and free-buffer replacement.
// ----------------------------------------------------------------------------
// Release, pin and unpin update the reference count; when a release drops
// the count to zero the buffer is also relinked (a tag read, 8 hash steps
// and the link read, unlink and push). A get hashes the block number and
// walks its bucket from the most recently used end; on a miss it then scans
// the buckets for a free buffer and, when it finds one, relinks and retags
// it and hands over the result. The walks through the link memories go one
// node at a time; one transaction is handled at a time.
// Reset is asynchronous and active low; the link lists come up in their
// initial order at once through per-entry valid bits, with no clearing pass.
// ----------------------------------------------------------------------------
module hashed_block_buffer_cache
  import hbbc_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata from bit 0: device[15:0], block_number[47:16], buffer_index[52:48],
  // zero padding[55:53]
  input  wire  [55:0] s_axis_tdata,
  // tuser from bit 0: operation[1:0]
  input  wire  [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // tdata from bit 0: result_buffer[4:0], hit[5], must_read[6], status[8:7],
  // zero padding[15:9]
  output logic [15:0] m_axis_tdata
);

  cmd_e             cmd;
  dp_status_t       st;
  logic [IDX_W-1:0] res_buf;
  logic             res_hit;
  logic             res_mr;
  logic [ST_W-1:0]  res_st;

  // The controller only issues commands; every register of the engine but
  // the controller's state lives in the datapath, which answers with the status flags it needs.
  hbbc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .st_i      (st),
    .s_ready_o (s_axis_tready),
    .cmd_o     (cmd)
  );

  hbbc_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .op_i            (s_axis_tuser),
    .dev_i           (s_axis_tdata[15:0]),
    .blk_i           (s_axis_tdata[47:16]),
    .idx_i           (s_axis_tdata[52:48]),
    .m_ready_i       (m_axis_tready),
    .st_o            (st),
    .m_valid_o       (m_axis_tvalid),
    .res_buf_o       (res_buf),
    .res_hit_o       (res_hit),
    .res_must_read_o (res_mr),
    .res_status_o    (res_st)
  );

  // Result fields are packed from the lowest bit up with zero padding.
  assign m_axis_tdata = {7'b0000000, res_st, res_mr, res_hit, res_buf};

endmodule
`default_nettype wire

// ===== design/hbbc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Hashed block buffer cache controller
// Sequences hashing, bucket search, free-buffer scan, count updates and list relinking.
// ----------------------------------------------------------------------------
module hbbc_ctrl
  import hbbc_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        s_valid_i,
  input  dp_status_t st_i,
  output logic       s_ready_o,
  output cmd_e       cmd_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = CMD_NONE;
    s_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o = CMD_LOAD;
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        cmd_o = CMD_MOD_STEP;
        if (st_i.mod_last) begin
          state_d = (st_i.op == OP_GET) ? S_SRCH_HEAD : S_LNK_RD;
        end
      end
      S_SRCH_HEAD: begin
        cmd_o   = CMD_RD_HEAD_NEXT;
        state_d = S_SRCH_FIRST;
      end
      S_SRCH_FIRST: begin
        cmd_o   = CMD_LOAD_NEXT_FIRST;
        state_d = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        if (st_i.srch_end) begin
          cmd_o   = CMD_SCAN_INIT;
          state_d = S_SCAN_HEAD;
        end else if (st_i.tag_match) begin
          cmd_o   = CMD_HIT;
          state_d = S_DONE;
        end else begin
          cmd_o   = CMD_RD_NODE_NEXT;
          state_d = S_SRCH_ADV;
        end
      end
      S_SRCH_ADV: begin
        cmd_o   = CMD_ADV_NEXT;
        state_d = S_SRCH_CHK;
      end
      S_SCAN_HEAD: begin
        cmd_o   = CMD_RD_SCAN_PREV;
        state_d = S_SCAN_FIRST;
      end
      S_SCAN_FIRST: begin
        cmd_o   = CMD_LOAD_PREV_FIRST;
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (st_i.scan_end) begin
          if (st_i.last_bucket) begin
            cmd_o   = CMD_NO_FREE;
            state_d = S_DONE;
          end else begin
            cmd_o   = CMD_NEXT_BUCKET;
            state_d = S_SCAN_HEAD;
          end
        end else if (st_i.cnt_zero) begin
          state_d = S_LNK_RD;
        end else begin
          cmd_o   = CMD_RD_NODE_PREV;
          state_d = S_SCAN_ADV;
        end
      end
      S_SCAN_ADV: begin
        cmd_o   = CMD_ADV_PREV;
        state_d = S_SCAN_CHK;
      end
      S_COUNT: begin
        cmd_o   = CMD_COUNT;
        state_d = st_i.relink ? S_REL_TAG : S_DONE;
      end
      S_REL_TAG: begin
        cmd_o   = CMD_MOD_TAG;
        state_d = S_MOD;
      end
      S_LNK_RD: begin
        cmd_o   = CMD_RD_LINKS;
        state_d = S_LNK_UNLINK;
      end
      S_LNK_UNLINK: begin
        cmd_o   = CMD_UNLINK;
        state_d = S_LNK_HEAD;
      end
      S_LNK_HEAD: begin
        cmd_o   = CMD_RD_HEAD_NEXT;
        state_d = S_LNK_PUSH_A;
      end
      S_LNK_PUSH_A: begin
        cmd_o   = CMD_PUSH_A;
        state_d = S_LNK_PUSH_B;
      end
      S_LNK_PUSH_B: begin
        cmd_o   = CMD_PUSH_B;
        state_d = (st_i.op == OP_GET) ? S_RETAG : S_DONE;
      end
      S_RETAG: begin
        cmd_o   = CMD_RETAG;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!st_i.out_busy) begin
          cmd_o   = CMD_EMIT;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    // Non-get operations skip hashing and go straight to the count update.
    if (state_q == S_IDLE && s_valid_i && st_i.op != OP_GET) begin
      state_d = S_COUNT;
    end
  end

endmodule
`default_nettype wire

// ===== design/hbbc_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Hashed block buffer cache datapath
// Tag store, reference counts, link memories, hash unit and result register.
// ----------------------------------------------------------------------------
module hbbc_dpath
  import hbbc_pkg::*;
(
  input  wire              clk_i,
  input  wire              rst_ni,
  input  cmd_e             cmd_i,
  input  wire [OP_W-1:0]   op_i,
  input  wire [DEV_W-1:0]  dev_i,
  input  wire [BLK_W-1:0]  blk_i,
  input  wire [IDX_W-1:0]  idx_i,
  input  wire              m_ready_i,
  output dp_status_t       st_o,
  output logic             m_valid_o,
  output logic [IDX_W-1:0] res_buf_o,
  output logic             res_hit_o,
  output logic             res_must_read_o,
  output logic [ST_W-1:0]  res_status_o
);

  localparam link_tab_t RST_NEXT = init_links(1'b1);
  localparam link_tab_t RST_PREV = init_links(1'b0);
  localparam int        V_W      = BKT_W + 4;

  op_e               op_q;
  logic [DEV_W-1:0]  dev_q;
  logic [BLK_W-1:0]  blk_q;
  logic [NODE_W-1:0] node_q;
  logic [STEP_W-1:0] steps_q;
  logic [BKT_W-1:0]  scan_q;
  logic [BKT_W-1:0]  rem_q;
  logic [BLK_W-1:0]  word_q;
  logic [DIG_W-1:0]  dig_q;

  logic [DEV_W-1:0]  tag_dev_q [NUM_BUFFERS];
  logic [BLK_W-1:0]  tag_blk_q [NUM_BUFFERS];
  logic [CNT_W-1:0]  cnt_q     [NUM_BUFFERS];
  logic              cv_q      [NUM_BUFFERS];

  logic [NODE_W-1:0]     next_mem [NODE_COUNT];
  logic [NODE_W-1:0]     prev_mem [NODE_COUNT];
  logic [NODE_COUNT-1:0] nvld_q, pvld_q;
  logic [NODE_W-1:0]     nrd_q, prd_q;

  logic [IDX_W-1:0] res_buf_q;
  logic             res_hit_q, res_mr_q;
  status_e          res_st_q;
  logic             m_valid_q;
  logic [IDX_W-1:0] out_buf_q;
  logic             out_hit_q, out_mr_q;
  logic [ST_W-1:0]  out_st_q;

  logic [BUF_W-1:0]  nbuf;
  logic [NODE_W-1:0] head_home, head_scan;
  logic              is_buf;
  logic [V_W-1:0]    v;
  logic [BKT_W-1:0]  rem_next;

  logic              n_re, p_re, n_we, p_we;
  logic [NODE_W-1:0] n_ra, p_ra, n_wa, p_wa, n_wd, p_wd;

  assign nbuf      = node_q[BUF_W-1:0];
  assign is_buf    = node_q < NODE_W'(NUM_BUFFERS);
  assign head_home = NODE_W'(NUM_BUFFERS) + NODE_W'(rem_q);
  assign head_scan = NODE_W'(NUM_BUFFERS) + NODE_W'(scan_q);

  // Remainder step: (rem * 16 + digit) mod buckets, by restoring subtraction.
  always_comb begin
    v = {rem_q, word_q[BLK_W-1 -: 4]};
    for (int k = 3; k >= 0; k--) begin
      if (v >= V_W'(NUM_BUCKETS << k)) begin
        v = v - V_W'(NUM_BUCKETS << k);
      end
    end
    rem_next = v[BKT_W-1:0];
  end

  always_comb begin
    st_o.op          = (cmd_i == CMD_LOAD) ? op_e'(op_i) : op_q;
    st_o.mod_last    = dig_q == DIG_W'(MOD_DIGITS - 1);
    st_o.srch_end    = node_q == head_home || !is_buf || steps_q == STEP_W'(NODE_COUNT);
    st_o.scan_end    = node_q == head_scan || !is_buf || steps_q == STEP_W'(NODE_COUNT);
    st_o.tag_match   = tag_dev_q[nbuf] == dev_q && tag_blk_q[nbuf] == blk_q;
    st_o.cnt_zero    = cnt_q[nbuf] == '0;
    st_o.last_bucket = scan_q == BKT_W'(NUM_BUCKETS - 1);
    st_o.relink      = op_q == OP_RELEASE && is_buf && cnt_q[nbuf] == CNT_W'(1);
    st_o.out_busy    = m_valid_q && !m_ready_i;
  end

  // Link memory port control.
  always_comb begin
    n_re = 1'b0; n_ra = node_q;
    p_re = 1'b0; p_ra = node_q;
    n_we = 1'b0; n_wa = node_q; n_wd = nrd_q;
    p_we = 1'b0; p_wa = node_q; p_wd = prd_q;
    case (cmd_i)
      CMD_RD_HEAD_NEXT: begin
        n_re = 1'b1;
        n_ra = head_home;
      end
      CMD_RD_NODE_NEXT: n_re = 1'b1;
      CMD_RD_SCAN_PREV: begin
        p_re = 1'b1;
        p_ra = head_scan;
      end
      CMD_RD_NODE_PREV: p_re = 1'b1;
      CMD_RD_LINKS: begin
        n_re = 1'b1;
        p_re = 1'b1;
      end
      CMD_UNLINK: begin
        n_we = 1'b1; n_wa = prd_q; n_wd = nrd_q;
        p_we = 1'b1; p_wa = nrd_q; p_wd = prd_q;
      end
      CMD_PUSH_A: begin
        n_we = 1'b1; n_wa = node_q; n_wd = nrd_q;
        p_we = 1'b1; p_wa = nrd_q;  p_wd = node_q;
      end
      CMD_PUSH_B: begin
        p_we = 1'b1; p_wa = node_q;    p_wd = head_home;
        n_we = 1'b1; n_wa = head_home; n_wd = node_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (n_we) begin
      next_mem[n_wa] <= n_wd;
    end
    if (p_we) begin
      prev_mem[p_wa] <= p_wd;
    end
    if (n_re) begin
      nrd_q <= nvld_q[n_ra] ? next_mem[n_ra] : RST_NEXT[n_ra];
    end
    if (p_re) begin
      prd_q <= pvld_q[p_ra] ? prev_mem[p_ra] : RST_PREV[p_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nvld_q <= '0;
      pvld_q <= '0;
    end else begin
      if (n_we) begin
        nvld_q[n_wa] <= 1'b1;
      end
      if (p_we) begin
        pvld_q[p_wa] <= 1'b1;
      end
    end
  end

  // Operation registers, walk pointer and hash unit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OP_GET;
    end else if (cmd_i == CMD_LOAD) begin
      op_q <= op_e'(op_i);
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        dev_q  <= dev_i;
        blk_q  <= blk_i;
        node_q <= NODE_W'(idx_i);
        word_q <= blk_i;
        rem_q  <= '0;
        dig_q  <= '0;
      end
      CMD_MOD_TAG: begin
        word_q <= tag_blk_q[nbuf];
        rem_q  <= '0;
        dig_q  <= '0;
      end
      CMD_MOD_STEP: begin
        rem_q  <= rem_next;
        word_q <= {word_q[BLK_W-5:0], 4'b0000};
        dig_q  <= dig_q + DIG_W'(1);
      end
      CMD_LOAD_NEXT_FIRST: begin
        node_q  <= nrd_q;
        steps_q <= '0;
      end
      CMD_ADV_NEXT: begin
        node_q  <= nrd_q;
        steps_q <= steps_q + STEP_W'(1);
      end
      CMD_SCAN_INIT: scan_q <= '0;
      CMD_NEXT_BUCKET: scan_q <= scan_q + BKT_W'(1);
      CMD_LOAD_PREV_FIRST: begin
        node_q  <= prd_q;
        steps_q <= '0;
      end
      CMD_ADV_PREV: begin
        node_q  <= prd_q;
        steps_q <= steps_q + STEP_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Tag store and reference counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        tag_dev_q[i] <= '0;
        tag_blk_q[i] <= '0;
        cnt_q[i]     <= '0;
        cv_q[i]      <= 1'b0;
      end
    end else begin
      case (cmd_i)
        CMD_HIT: begin
          cv_q[nbuf] <= 1'b1;
          if (cnt_q[nbuf] != '1) begin
            cnt_q[nbuf] <= cnt_q[nbuf] + CNT_W'(1);
          end
        end
        CMD_RETAG: begin
          tag_dev_q[nbuf] <= dev_q;
          tag_blk_q[nbuf] <= blk_q;
          cv_q[nbuf]      <= 1'b1;
          cnt_q[nbuf]     <= CNT_W'(1);
        end
        CMD_COUNT: begin
          if (is_buf) begin
            if (op_q == OP_PIN) begin
              if (cnt_q[nbuf] != '1) begin
                cnt_q[nbuf] <= cnt_q[nbuf] + CNT_W'(1);
              end
            end else if (cnt_q[nbuf] != '0) begin
              cnt_q[nbuf] <= cnt_q[nbuf] - CNT_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result of the current transaction.
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_HIT: begin
        res_buf_q <= IDX_W'(node_q);
        res_hit_q <= 1'b1;
        res_mr_q  <= !cv_q[nbuf];
        res_st_q  <= ST_OK;
      end
      CMD_RETAG: begin
        res_buf_q <= IDX_W'(node_q);
        res_hit_q <= 1'b0;
        res_mr_q  <= 1'b1;
        res_st_q  <= ST_OK;
      end
      CMD_NO_FREE: begin
        res_buf_q <= '0;
        res_hit_q <= 1'b0;
        res_mr_q  <= 1'b0;
        res_st_q  <= ST_NO_FREE;
      end
      CMD_COUNT: begin
        res_buf_q <= IDX_W'(node_q);
        res_hit_q <= 1'b0;
        res_mr_q  <= 1'b0;
        res_st_q  <= (is_buf && op_q != OP_PIN && cnt_q[nbuf] == '0) ? ST_UNDERFLOW : ST_OK;
      end
      default: begin
      end
    endcase
  end

  // Output register: holds a finished result until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i == CMD_EMIT) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_EMIT) begin
      out_buf_q <= res_buf_q;
      out_hit_q <= res_hit_q;
      out_mr_q  <= res_mr_q;
      out_st_q  <= res_st_q;
    end
  end

  assign m_valid_o       = m_valid_q;
  assign res_buf_o       = out_buf_q;
  assign res_hit_o       = out_hit_q;
  assign res_must_read_o = out_mr_q;
  assign res_status_o    = out_st_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == CMD_EMIT |-> !(m_valid_q && !m_ready_i))
    else $error("result emitted over an untaken result");

  a_retag_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == CMD_RETAG |=> cnt_q[$past(nbuf)] == CNT_W'(1))
    else $error("retagged buffer does not hold one reference");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == CMD_MOD_STEP |=> rem_q < BKT_W'(NUM_BUCKETS))
    else $error("hash remainder out of range");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == CMD_NEXT_BUCKET |=> scan_q < BKT_W'(NUM_BUCKETS))
    else $error("scan bucket out of range");

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hashed block buffer cache testbench
// Drives get, release, pin and unpin transactions through the input stream
// and checks every result against a behavioural copy of the bucket lists,
// tags and reference counts kept in the testbench, under varied idling.
// ----------------------------------------------------------------------------
module tb_top;
  import hbbc_pkg::*;

  localparam int HEAD0 = NUM_BUFFERS;

  typedef struct packed {
    logic [4:0] buf_idx;
    logic       hit;
    logic       must_read;
    status_e    status;
  } cache_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [15:0] m_axis_tdata;

  hashed_block_buffer_cache uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Mirror of the cache state.
  logic [15:0] mdl_dev [NUM_BUFFERS];
  logic [31:0] mdl_blk [NUM_BUFFERS];
  logic        mdl_valid [NUM_BUFFERS];
  logic [7:0]  mdl_refs [NUM_BUFFERS];
  int          mdl_next [NODE_COUNT];
  int          mdl_prev [NODE_COUNT];

  cache_result_t pending_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int sent_items = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;

  // Small pool of recently used tags so that gets hit often.
  logic [15:0] pool_dev [16];
  logic [31:0] pool_blk [16];

  function automatic void list_unlink(int n);
    mdl_next[mdl_prev[n]] = mdl_next[n];
    mdl_prev[mdl_next[n]] = mdl_prev[n];
  endfunction

  function automatic void list_push_mru(int n, int bucket);
    int head;
    int first;
    head = HEAD0 + bucket;
    first = mdl_next[head];
    mdl_next[n] = first;
    mdl_prev[n] = head;
    mdl_prev[first] = n;
    mdl_next[head] = n;
  endfunction

  function automatic void cache_reset();
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      mdl_next[HEAD0 + i] = HEAD0 + i;
      mdl_prev[HEAD0 + i] = HEAD0 + i;
    end
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      mdl_dev[i] = '0;
      mdl_blk[i] = '0;
      mdl_valid[i] = 1'b0;
      mdl_refs[i] = '0;
      list_push_mru(i, i % NUM_BUCKETS);
    end
  endfunction

  // Works out the result of one transaction and updates the mirror.
  function automatic cache_result_t cache_apply(op_e op, logic [15:0] dev,
                                                logic [31:0] blk, logic [4:0] idx);
    cache_result_t r;
    int home;
    int n;
    int m;
    int steps;
    bit found;
    r = '{buf_idx: idx, hit: 1'b0, must_read: 1'b0, status: ST_OK};
    found = 1'b0;
    n = 0;
    if (op == OP_GET) begin
      home = int'(blk % NUM_BUCKETS);
      n = mdl_next[HEAD0 + home];
      steps = 0;
      while (n != HEAD0 + home && n < NUM_BUFFERS && steps < NODE_COUNT) begin
        if (mdl_dev[n] == dev && mdl_blk[n] == blk) begin
          found = 1'b1;
          break;
        end
        n = mdl_next[n];
        steps++;
      end
      if (found) begin
        r.hit = 1'b1;
        if (mdl_refs[n] != 8'hff) mdl_refs[n]++;
      end else begin
        // Victim search: buckets from 0, each from its least recently used end.
        for (int j = 0; j < NUM_BUCKETS && !found; j++) begin
          m = mdl_prev[HEAD0 + j];
          steps = 0;
          while (m != HEAD0 + j && m < NUM_BUFFERS && steps < NODE_COUNT) begin
            if (mdl_refs[m] == 0) begin
              found = 1'b1;
              n = m;
              break;
            end
            m = mdl_prev[m];
            steps++;
          end
        end
        if (found) begin
          list_unlink(n);
          list_push_mru(n, home);
          mdl_dev[n] = dev;
          mdl_blk[n] = blk;
          mdl_valid[n] = 1'b0;
          mdl_refs[n] = 8'd1;
        end
      end
      if (found) begin
        r.buf_idx = 5'(n);
        if (!mdl_valid[n]) begin
          r.must_read = 1'b1;
          mdl_valid[n] = 1'b1;
        end
      end else begin
        r.buf_idx = '0;
        r.status = ST_NO_FREE;
      end
    end else if (int'(idx) < NUM_BUFFERS) begin
      if (op == OP_PIN) begin
        if (mdl_refs[idx] != 8'hff) mdl_refs[idx]++;
      end else if (mdl_refs[idx] == 0) begin
        r.status = ST_UNDERFLOW;
      end else begin
        mdl_refs[idx]--;
        if (op == OP_RELEASE && mdl_refs[idx] == 0) begin
          list_unlink(int'(idx));
          list_push_mru(int'(idx), int'(mdl_blk[idx] % NUM_BUCKETS));
        end
      end
    end
    return r;
  endfunction

  // Sends one transaction, with optional idle cycles before it. Valid stays
  // high from one transaction to the next when there is no idle gap.
  task automatic send_op(op_e op, logic [15:0] dev, logic [31:0] blk, logic [4:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    pending_results.push_back(cache_apply(op, dev, blk, idx));
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {3'b000, idx, blk, dev};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_items++;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  // Receiver ready, with random stalls and an optional long hold-off.
  always @(posedge clk_i) begin
    m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checker.
  always @(posedge clk_i) begin
    cache_result_t got;
    cache_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = cache_result_t'({m_axis_tdata[4:0], m_axis_tdata[5], m_axis_tdata[6],
                             m_axis_tdata[8:7]});
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got !== want || m_axis_tdata[15:9] !== 7'd0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: buf %0d/%0d hit %0d/%0d read %0d/%0d status %0d/%0d",
                     want.buf_idx, got.buf_idx, want.hit, got.hit,
                     want.must_read, got.must_read, want.status, got.status);
        end
      end
    end
  end

  function automatic logic [31:0] rand_blk();
    case ($urandom_range(3))
      0: return 32'($urandom_range(40));
      1: return 32'hffff_ffff - 32'($urandom_range(20));
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed();
    send_op(OP_GET, 16'h0000, 32'h0000_0000, 5'd0);   // hits a reset tag in bucket 0
    send_op(OP_GET, 16'hffff, 32'hffff_ffff, 5'd31);
    send_op(OP_GET, 16'hffff, 32'hffff_ffff, 5'd0);   // hit, already valid
    send_op(OP_RELEASE, 16'h0, 32'h0, 5'd0);
    send_op(OP_PIN, 16'h0, 32'h0, 5'd31);
    send_op(OP_UNPIN, 16'h0, 32'h0, 5'd31);
    send_op(OP_UNPIN, 16'h0, 32'h0, 5'd31);            // underflow
    send_op(OP_RELEASE, 16'h0, 32'h0, 5'd7);           // underflow
    send_op(OP_GET, 16'h1234, 32'd13, 5'd0);
    send_op(OP_RELEASE, 16'h0, 32'h0, 5'd0);
    send_op(OP_RELEASE, 16'h0, 32'h0, 5'd0);
    wait_drained();
  endtask

  // Pins a buffer 260 times to show saturation, then unpins it back to zero and once more to underflow.
  task automatic test_saturation();
    for (int i = 0; i < 260; i++) send_op(OP_PIN, '0, '0, 5'd5);
    for (int i = 0; i < 255; i++) send_op(OP_UNPIN, '0, '0, 5'd5);
    send_op(OP_UNPIN, '0, '0, 5'd5);
    wait_drained();
  endtask

  // Holds every buffer so that a get finds no free one.
  task automatic test_no_free();
    for (int i = 0; i < NUM_BUFFERS; i++) send_op(OP_PIN, '0, '0, 5'(i));
    send_op(OP_GET, 16'h0bad, 32'h0000_beef, 5'd3);
    send_op(OP_GET, 16'h0000, 32'h0000_0000, 5'd0);
    for (int i = 0; i < NUM_BUFFERS; i++) send_op(OP_RELEASE, '0, '0, 5'(i));
    wait_drained();
  endtask

  function automatic logic [4:0] cache_apply_peek();
    return pending_results[$].buf_idx;
  endfunction

  // Mostly well-formed get/release pairs over a small tag pool, plus noise.
  task automatic test_random(int count);
    int k;
    logic [4:0] held [$];
    logic [4:0] b;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(99);
      if (k < 45) begin
        b = 5'($urandom_range(15));
        if ($urandom_range(3) == 0) begin
          pool_dev[b] = 16'($urandom());
          pool_blk[b] = rand_blk();
        end
        send_op(OP_GET, pool_dev[b], pool_blk[b], 5'($urandom()));
        held.push_back(cache_apply_peek());
      end else if (k < 75 && held.size() != 0) begin
        send_op(OP_RELEASE, 16'($urandom()), $urandom(),
                held[$urandom_range(held.size() - 1)]);
        if (held.size() > 12) void'(held.pop_front());
      end else begin
        send_op(op_e'($urandom_range(3)), 16'($urandom()), $urandom(),
                5'($urandom()));
      end
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        test_random(30);
        wait_drained();
      end
    join
  endtask

  initial begin
    cache_reset();
    for (int i = 0; i < 16; i++) begin
      pool_dev[i] = 16'(i % 3);
      pool_blk[i] = 32'(i);
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_saturation();
    test_no_free();
    test_backpressure();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(240); wait_drained();
    send_idle_pct = 57; recv_stall_pct = 0;  test_random(240); wait_drained();
    send_idle_pct = 0;  recv_stall_pct = 57; test_random(240); wait_drained();
    send_idle_pct = 37; recv_stall_pct = 37; test_random(240); wait_drained();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(170);
    wait_drained();
    repeat (100) @(posedge clk_i);
    $display("Covered %0d transactions and %0d results: hits, misses, no free buffer,",
             sent_items, results_seen);
    $display("count saturation and underflow, under back-pressure and idling.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("tb_top: errors");
    $finish;
  end

endmodule
